// ===== hw/rtl/fir_pkg.sv =====
// Shared types, widths and codes for the FIR filter core.
package fir_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int IDX_W = 4;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int FRAC_W = 15;
  localparam int TAPS_DEFAULT = 16;

  // Input item kinds carried on tuser
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Per-cycle commands to every cell of the chain
  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

  // Commands to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/fir_cell.sv =====
// One filter cell: holds a coefficient and a history sample, passes them along the chain.
module fir_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fir_pkg::cell_ctrl_t                   ctrl,
  input  logic                                  wr_en,
  input  logic signed [fir_pkg::COEF_W-1:0]     wr_coef,
  input  logic signed [fir_pkg::COEF_W-1:0]     up_coef,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]   up_sample,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]   down_sample,
  output logic signed [fir_pkg::COEF_W-1:0]     coef,
  output logic signed [fir_pkg::SAMPLE_W-1:0]   sample
);
  import fir_pkg::*;

  // Write, rotate toward cell 0, or shift a new sample in
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      sample <= '0;
    end else if (wr_en) begin
      coef <= wr_coef;
    end else if (ctrl.rotate) begin
      coef <= up_coef;
      sample <= up_sample;
    end else if (ctrl.insert) begin
      sample <= down_sample;
    end
  end

endmodule

// ===== hw/rtl/fir_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module fir_mac #(
  parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fir_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [fir_pkg::COEF_W-1:0]     coef,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]   sample,
  output logic signed [fir_pkg::SAMPLE_W-1:0]   result,
  output logic                                  saturated
);
  import fir_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int Q_W = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q;
  logic                     over;
  logic                     under;

  // Register the product of the cell at the head of the chain
  always_ff @(posedge clk) begin
    prod <= coef * sample;
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.en;
    end
  end

  // Accumulate exactly
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Round to nearest, ties up, then clip to the sample range
  always_comb begin
    rnd = acc + ACC_W'(1 << (FRAC_W - 1));
    q = rnd[ACC_W-1:FRAC_W];
    over = q > $signed(Q_W'((1 << (SAMPLE_W - 1)) - 1));
    under = q < -$signed(Q_W'(1 << (SAMPLE_W - 1)));
    saturated = over | under;
    if (over) begin
      result = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (under) begin
      result = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      result = q[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/fir_filter_core.sv =====
// Top level of the streaming FIR filter: cell chain, sequencer and output register.
//
// Channel  | Dir | Handshake                     | Payload
// ---------+-----+-------------------------------+----------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: action; tdata: sample_in,
//          |     |                               |   tap_index, tap_value
// m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: saturated; tdata: sample_out
//
// A coefficient item is taken while the sequencer is idle and writes its cell directly.
// A sample item runs one multiply per tap as the cell chain rotates past the single
// multiplier, then passes the product, accumulate and result stages.
// rst is synchronous; it clears the sequencer, the output valid and every cell.
// The result waits in the output register while the next item is already taken;
// a finished sum holds in the accumulator until that register is free.
module fir_filter_core #(
  parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_in[15:0], tap_index[19:16], tap_value[35:20]
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample_out[15:0]
  output logic [0:0]  m_axis_tuser    // saturated[0]
);
  import fir_pkg::*;

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  state_t                     state;
  state_t                     state_next;
  logic [CNT_W-1:0]           cnt;
  cell_ctrl_t                 cell_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic                       accept;
  logic                       wr_go;
  logic                       out_load;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_index;
  logic signed [COEF_W-1:0]   in_coef;
  logic signed [COEF_W-1:0]   coef_q [TAPS];
  logic signed [SAMPLE_W-1:0] sample_q [TAPS];
  logic [TAPS-1:0]            cell_we;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic                       mac_sat;

  // Unpack the input item
  assign in_sample = s_axis_tdata[15:0];
  assign in_index = s_axis_tdata[19:16];
  assign in_coef = s_axis_tdata[35:20];
  assign accept = s_axis_tvalid & s_axis_tready;
  assign wr_go = accept & (s_axis_tuser[0] == ACT_WRITE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_axis_tuser[0] == ACT_FILTER)) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == CNT_W'(TAPS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer; ready is always high in idle
  always_comb begin
    s_axis_tready = 1'b0;
    cell_ctrl = '0;
    mac_ctrl = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cell_ctrl.insert = s_axis_tvalid && (s_axis_tuser[0] == ACT_FILTER);
        mac_ctrl.clear = cell_ctrl.insert;
      end
      ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.en = 1'b1;
      end
      ST_DRAIN: ;
      ST_DONE: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // State and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Row of cells: rotate toward cell 0, insert new samples at cell 0
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i < (1 << IDX_W)) begin : g_we
      assign cell_we[i] = wr_go && (in_index == IDX_W'(i));
    end else begin : g_no_we
      assign cell_we[i] = 1'b0;
    end

    fir_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .wr_en       (cell_we[i]),
      .wr_coef     (in_coef),
      .up_coef     (coef_q[(i + 1) % TAPS]),
      .up_sample   (sample_q[(i + 1) % TAPS]),
      .down_sample ((i == 0) ? in_sample : sample_q[(i + TAPS - 1) % TAPS]),
      .coef        (coef_q[i]),
      .sample      (sample_q[i])
    );
  end

  // Multiply-accumulate on the head of the chain
  fir_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .coef      (coef_q[0]),
    .sample    (sample_q[0]),
    .result    (mac_result),
    .saturated (mac_sat)
  );

  // Output register: load a finished item, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= mac_result;
      m_axis_tuser <= mac_sat;
    end
  end

endmodule
